// ----- design/chxd_pkg.sv -----
// chxd_pkg: types and constants shared by the chained xor packet decoder
// no dependencies; used by chxd_core, chxd_out_buf and chained_xor_packet_decoder
`timescale 1ns / 1ps

package chxd_pkg;

  // frame phase, one value per header byte plus the payload
  typedef enum logic [2:0] {
    PH_CODE   = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_RKEY   = 3'd3,
    PH_CSUM   = 3'd4,
    PH_DATA   = 3'd5
  } phase_t;

  // register map
  localparam logic [0:0] ADDR_FIXED_KEY = 1'b0;
  localparam logic [7:0] FIXED_KEY_RESET = 8'd169;

  // position of the checksum byte in the xor chains
  localparam logic [7:0] CSUM_POS = 8'd1;
  // offset from payload index to chain position
  localparam logic [7:0] DATA_POS_OFFSET = 8'd2;

  // one decoded result beat
  typedef struct packed {
    logic       has_data;
    logic [7:0] plain_byte;
    logic       frame_end;
    logic       checksum_ok;
  } result_t;

endpackage

// ----- design/chxd_core.sv -----
// chxd_core: frame state registers and the two-layer xor unchaining of one byte
// depends on chxd_pkg for the phase type and result struct
`timescale 1ns / 1ps

module chxd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        fixed_key,
  output logic              res_valid,
  output chxd_pkg::result_t res
);

  chxd_pkg::phase_t phase, phase_next;
  logic [15:0] payload_length, payload_length_next;
  logic [7:0]  random_key, random_key_next;
  logic [15:0] payload_position, payload_position_next;
  logic [7:0]  previous_encoded, previous_encoded_next;
  logic [7:0]  previous_inner, previous_inner_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  expected_sum, expected_sum_next;

  logic [7:0]  pos;
  logic [7:0]  prev_enc_use;
  logic [7:0]  prev_inner_use;
  logic [7:0]  inner;
  logic [7:0]  plain;
  logic [15:0] position_inc;

  // chain inputs: both chains restart at the checksum byte
  always_comb begin
    if (phase == chxd_pkg::PH_CSUM) begin
      pos            = chxd_pkg::CSUM_POS;
      prev_enc_use   = 8'd0;
      prev_inner_use = 8'd0;
    end else begin
      pos            = payload_position[7:0] + chxd_pkg::DATA_POS_OFFSET;
      prev_enc_use   = previous_encoded;
      prev_inner_use = previous_inner;
    end
  end

  // two xor layers
  assign inner        = rx_byte ^ (prev_enc_use + fixed_key + pos);
  assign plain        = inner ^ (prev_inner_use + random_key + pos);
  assign position_inc = payload_position + 16'd1;

  // next state
  always_comb begin
    phase_next            = phase;
    payload_length_next   = payload_length;
    random_key_next       = random_key;
    payload_position_next = payload_position;
    previous_encoded_next = previous_encoded;
    previous_inner_next   = previous_inner;
    running_sum_next      = running_sum;
    expected_sum_next     = expected_sum;
    case (phase)
      chxd_pkg::PH_LEN_LO: begin
        payload_length_next = {payload_length[15:8], rx_byte};
        phase_next          = chxd_pkg::PH_LEN_HI;
      end
      chxd_pkg::PH_LEN_HI: begin
        payload_length_next = {rx_byte, payload_length[7:0]};
        phase_next          = chxd_pkg::PH_RKEY;
      end
      chxd_pkg::PH_RKEY: begin
        random_key_next = rx_byte;
        phase_next      = chxd_pkg::PH_CSUM;
      end
      chxd_pkg::PH_CSUM: begin
        previous_encoded_next = rx_byte;
        previous_inner_next   = inner;
        running_sum_next      = 8'd0;
        payload_position_next = 16'd0;
        expected_sum_next     = plain;
        phase_next = (payload_length == 16'd0) ? chxd_pkg::PH_CODE : chxd_pkg::PH_DATA;
      end
      chxd_pkg::PH_DATA: begin
        previous_encoded_next = rx_byte;
        previous_inner_next   = inner;
        running_sum_next      = running_sum + plain;
        payload_position_next = position_inc;
        if (position_inc >= payload_length) begin
          phase_next = chxd_pkg::PH_CODE;
        end
      end
      default: begin
        phase_next = chxd_pkg::PH_LEN_LO;
      end
    endcase
  end

  // result of this byte
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    case (phase)
      chxd_pkg::PH_CSUM: begin
        res_valid       = (payload_length == 16'd0);
        res.frame_end   = 1'b1;
        res.checksum_ok = (plain == 8'd0);
      end
      chxd_pkg::PH_DATA: begin
        res_valid      = 1'b1;
        res.has_data   = 1'b1;
        res.plain_byte = plain;
        if (position_inc >= payload_length) begin
          res.frame_end   = 1'b1;
          res.checksum_ok = ((running_sum + plain) == expected_sum);
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= chxd_pkg::PH_CODE;
      payload_length   <= 16'd0;
      random_key       <= 8'd0;
      payload_position <= 16'd0;
      previous_encoded <= 8'd0;
      previous_inner   <= 8'd0;
      running_sum      <= 8'd0;
      expected_sum     <= 8'd0;
    end else if (take) begin
      phase            <= phase_next;
      payload_length   <= payload_length_next;
      random_key       <= random_key_next;
      payload_position <= payload_position_next;
      previous_encoded <= previous_encoded_next;
      previous_inner   <= previous_inner_next;
      running_sum      <= running_sum_next;
      expected_sum     <= expected_sum_next;
    end
  end

endmodule

// ----- design/chxd_out_buf.sv -----
// chxd_out_buf: two-entry result register with skid slot, parts input ready from output ready
// depends on chxd_pkg for the result struct
`timescale 1ns / 1ps

module chxd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  chxd_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output chxd_pkg::result_t out_data
);

  chxd_pkg::result_t slot0, slot1;
  logic [1:0] count, count_next;
  logic       pop;
  logic       push_head;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = slot0;
  assign space     = (count != 2'd2);

  // new beat lands in the head slot when the head is empty or leaving
  assign push_head = push && (count == 2'd0 || (count == 2'd1 && pop));

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // slot moves
  always_ff @(posedge clk) begin
    if (push_head) begin
      slot0 <= push_data;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && !push_head) begin
      slot1 <= push_data;
    end
  end

endmodule

// ----- design/chained_xor_packet_decoder.sv -----
// chained_xor_packet_decoder: top level with apb register port, decode core and result buffer
// depends on chxd_pkg, chxd_core and chxd_out_buf
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        input      in_valid / in_ready    rx_byte
// out       output     out_valid / out_ready  has_data, plain_byte, frame_end, checksum_ok
// cfg       input      psel / penable / pready  paddr, pwdata, prdata (fixed_key at 0x0)
//
// one byte is taken per cycle while in_ready is high; a result is written into the
// output buffer when its byte is taken. the byte chain is one xor pair with two
// 8-bit adds per layer. in_ready drops only when both result slots are full.
// synchronous reset returns to the code byte phase and sets fixed_key to 169.

module chained_xor_packet_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        has_data,
  output logic [7:0]  plain_byte,
  output logic        frame_end,
  output logic        checksum_ok,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              take;
  logic              res_valid;
  logic              space;
  logic [7:0]        fixed_key;
  chxd_pkg::result_t res;
  chxd_pkg::result_t out_data;

  // config register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_key <= chxd_pkg::FIXED_KEY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == chxd_pkg::ADDR_FIXED_KEY) begin
      fixed_key <= pwdata[7:0];
    end
  end

  assign prdata = (paddr == chxd_pkg::ADDR_FIXED_KEY) ? {24'd0, fixed_key} : 32'd0;

  // input beat handshake
  assign in_ready = space;
  assign take     = in_valid && in_ready;

  chxd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .fixed_key (fixed_key),
    .res_valid (res_valid),
    .res       (res)
  );

  chxd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // output beat fields
  assign has_data    = out_data.has_data;
  assign plain_byte  = out_data.plain_byte;
  assign frame_end   = out_data.frame_end;
  assign checksum_ok = out_data.checksum_ok;

endmodule

// ----- bench/chxd_checker.sv -----
// chxd_checker: watches the byte and result channels of the chained xor packet decoder,
// decodes each accepted byte itself and compares every result beat with its own prediction
// depends on chxd_pkg
`timescale 1ns / 1ps

module chxd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        has_data,
  input  logic [7:0]  plain_byte,
  input  logic        frame_end,
  input  logic        checksum_ok,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  // decoder state as this side sees it
  chxd_pkg::phase_t fr_phase;
  logic [15:0] fr_len;
  logic [7:0]  fr_rkey;
  logic [15:0] fr_idx;
  logic [7:0]  last_enc;
  logic [7:0]  last_inner;
  logic [7:0]  pay_sum;
  logic [7:0]  csum_plain;
  logic [7:0]  key_q;

  // decoded results still to come out of the block, oldest first
  chxd_pkg::result_t due_results [$];

  // strip both xor layers from one byte and advance the two chains
  function automatic logic [7:0] chain_undo(input logic [7:0] enc, input logic [7:0] pos);
    logic [7:0] outer_mask;
    logic [7:0] inner_mask;
    logic [7:0] inner;
    outer_mask = last_enc + key_q + pos;
    inner      = enc ^ outer_mask;
    inner_mask = last_inner + fr_rkey + pos;
    last_enc   = enc;
    last_inner = inner;
    return inner ^ inner_mask;
  endfunction

  // walk one accepted frame byte through the header and payload phases
  function automatic void decode_byte(input logic [7:0] b);
    chxd_pkg::result_t r;
    r = '0;
    case (fr_phase)
      chxd_pkg::PH_LEN_LO: begin
        fr_len[7:0] = b;
        fr_phase    = chxd_pkg::PH_LEN_HI;
      end
      chxd_pkg::PH_LEN_HI: begin
        fr_len[15:8] = b;
        fr_phase     = chxd_pkg::PH_RKEY;
      end
      chxd_pkg::PH_RKEY: begin
        fr_rkey  = b;
        fr_phase = chxd_pkg::PH_CSUM;
      end
      chxd_pkg::PH_CSUM: begin
        last_enc   = '0;
        last_inner = '0;
        pay_sum    = '0;
        fr_idx     = '0;
        csum_plain = chain_undo(b, chxd_pkg::CSUM_POS);
        if (fr_len == 16'd0) begin
          // empty payload closes the frame on the checksum byte
          r.frame_end   = 1'b1;
          r.checksum_ok = (csum_plain == 8'd0);
          due_results.push_back(r);
          fr_phase = chxd_pkg::PH_CODE;
        end else begin
          fr_phase = chxd_pkg::PH_DATA;
        end
      end
      chxd_pkg::PH_DATA: begin
        r.has_data   = 1'b1;
        r.plain_byte = chain_undo(b, fr_idx[7:0] + chxd_pkg::DATA_POS_OFFSET);
        pay_sum      = pay_sum + r.plain_byte;
        fr_idx       = fr_idx + 16'd1;
        if (fr_idx >= fr_len) begin
          r.frame_end   = 1'b1;
          r.checksum_ok = (pay_sum == csum_plain);
          fr_phase      = chxd_pkg::PH_CODE;
        end
        due_results.push_back(r);
      end
      default: begin
        // code byte, skipped
        fr_phase = chxd_pkg::PH_LEN_LO;
      end
    endcase
  endfunction

  // sample every channel at the rising edge
  always @(posedge clk) begin
    chxd_pkg::result_t got;
    chxd_pkg::result_t want;
    if (rst) begin
      fr_phase   = chxd_pkg::PH_CODE;
      fr_len     = '0;
      fr_rkey    = '0;
      fr_idx     = '0;
      last_enc   = '0;
      last_inner = '0;
      pay_sum    = '0;
      csum_plain = '0;
      key_q      = chxd_pkg::FIXED_KEY_RESET;
      due_results.delete();
    end else begin
      // result beat
      if (out_valid && out_ready) begin
        got = '{has_data: has_data, plain_byte: plain_byte, frame_end: frame_end,
                checksum_ok: checksum_ok};
        if (due_results.size() == 0) begin
          if (errors < 10) begin
            $display("%t: unexpected result: got %0d/%02h/%0d/%0d",
                     $realtime, got.has_data, got.plain_byte, got.frame_end,
                     got.checksum_ok);
          end
          errors++;
        end else begin
          want = due_results.pop_front();
          if (got.has_data !== want.has_data || got.plain_byte !== want.plain_byte ||
              got.frame_end !== want.frame_end || got.checksum_ok !== want.checksum_ok) begin
            if (errors < 10) begin
              $display("%t: mismatch: expected %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
                       $realtime, want.has_data, want.plain_byte, want.frame_end,
                       want.checksum_ok, got.has_data, got.plain_byte, got.frame_end,
                       got.checksum_ok);
            end
            errors++;
          end
        end
      end
      // byte beat, decoded with the key held before this edge
      if (in_valid && in_ready) begin
        decode_byte(rx_byte);
      end
      // register write
      if (psel && penable && pwrite && pready && paddr == chxd_pkg::ADDR_FIXED_KEY) begin
        key_q = pwdata[7:0];
      end
    end
    pending <= due_results.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// tb_top: drives encoded frames and register writes into the chained xor packet decoder,
// stalls the result side at random and gives the verdict from the checker's error count
// depends on chxd_pkg, chained_xor_packet_decoder and chxd_checker
`timescale 1ns / 1ps

module tb_top;

  localparam int DIRECTED_BYTES = 24;
  localparam int RANDOM_BYTES   = 900;
  localparam int HOLD_OFF       = 250;
  localparam int HOLD_AT_BEAT   = 60;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_KEY} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        has_data;
  logic [7:0]  plain_byte;
  logic        frame_end;
  logic        checksum_ok;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int bytes_sent = 0;
  int stall_cycles = 0;
  bit idle_in = 1'b1;

  // encoder side: key in the register and the two xor chains of the frame being sent
  logic [7:0] cur_key = chxd_pkg::FIXED_KEY_RESET;
  logic [7:0] enc_last;
  logic [7:0] enc_inner;

  always #5 clk = ~clk;

  chained_xor_packet_decoder u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .has_data    (has_data),
    .plain_byte  (plain_byte),
    .frame_end   (frame_end),
    .checksum_ok (checksum_ok),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  chxd_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .has_data    (has_data),
    .plain_byte  (plain_byte),
    .frame_end   (frame_end),
    .checksum_ok (checksum_ok),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .errors      (errors),
    .pending     (pending)
  );

  function automatic logic [7:0] pick_byte(input fill_t fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hff;
      default:   return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // apply both xor layers, outer one with the given fixed key
  function automatic logic [7:0] chain_encode(input logic [7:0] plain, input logic [7:0] pos,
                                              input logic [7:0] rk, input logic [7:0] key);
    logic [7:0] inner_mask;
    logic [7:0] outer_mask;
    logic [7:0] inner;
    logic [7:0] enc;
    inner_mask = enc_inner + rk + pos;
    inner      = plain ^ inner_mask;
    outer_mask = enc_last + key + pos;
    enc        = inner ^ outer_mask;
    enc_inner  = inner;
    enc_last   = enc;
    return enc;
  endfunction

  // offer one byte after a random gap and hold it until taken
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = idle_in ? $urandom_range(0, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // stop offering and let every expected result drain out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // setup then access cycle; upper data bits are junk the register must drop
  task automatic write_fixed_key(input logic [7:0] k);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= chxd_pkg::ADDR_FIXED_KEY;
    pwdata  <= {24'($urandom), k};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_key  = k;
  endtask

  // one whole frame; split_at names the byte before which the fixed key is rewritten
  task automatic send_frame(input logic [15:0] len, input frame_kind_t kind,
                            input fill_t fill, input int split_at,
                            input logic [7:0] split_key);
    logic [7:0] body [$];
    logic [7:0] rk;
    logic [7:0] sum;
    logic [7:0] plain;
    logic [7:0] skew;
    int k;
    rk   = pick_byte(fill);
    sum  = '0;
    skew = (kind == FRAME_BAD_KEY) ? 8'($urandom_range(1, 255)) : 8'd0;
    for (k = 0; k < len; k++) begin
      body.push_back(pick_byte(fill));
      sum = sum + body[k];
    end
    if (kind == FRAME_BAD_SUM) begin
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    enc_last  = '0;
    enc_inner = '0;
    for (k = 0; k < len + 5; k++) begin
      if (k == split_at) begin
        drain();
        write_fixed_key(split_key);
      end
      case (k)
        0: push_byte(pick_byte(fill));
        1: push_byte(len[7:0]);
        2: push_byte(len[15:8]);
        3: push_byte(rk);
        default: begin
          // checksum byte sits at chain position 1, payload byte i at i+2
          plain = (k == 4) ? sum : body[k - 5];
          push_byte(chain_encode(plain, 8'(k - 3), rk, cur_key ^ skew));
        end
      endcase
    end
  endtask

  // result side: random stalls, calm stretches, and one long hold-off
  initial begin : result_sink
    int gap;
    int beats;
    bit calm;
    beats = 0;
    calm  = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (beats == HOLD_AT_BEAT) gap = HOLD_OFF;
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats++;
    end
  end

  // cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int cfg_n;
    int frame_n;
    int pick;
    int split_at;
    logic [15:0] len;
    frame_kind_t kind;
    cfg_n   = 0;
    frame_n = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty frames with good and bad checksum, extreme bytes,
    // key rewritten in the middle of a payload, all under the reset key at first
    send_frame(16'd0, FRAME_GOOD, FILL_ONES, -1, 8'h00);
    send_frame(16'd0, FRAME_BAD_SUM, FILL_ZERO, -1, 8'h00);
    send_frame(16'd1, FRAME_GOOD, FILL_ONES, -1, 8'h00);
    send_frame(16'd3, FRAME_BAD_SUM, FILL_ZERO, 6, 8'h00);

    // random frames, mostly well formed
    while (bytes_sent < DIRECTED_BYTES + RANDOM_BYTES) begin
      idle_in = ($urandom_range(0, 3) != 0);
      if (frame_n % 8 == 7) begin
        drain();
        case (cfg_n % 4)
          0:       write_fixed_key(8'hff);
          2:       write_fixed_key(8'h00);
          default: write_fixed_key(8'($urandom_range(0, 255)));
        endcase
        cfg_n++;
      end
      pick = $urandom_range(0, 9);
      kind = (pick < 7) ? FRAME_GOOD : ((pick < 9) ? FRAME_BAD_SUM : FRAME_BAD_KEY);
      // one long frame so chain positions wrap past 255
      len  = (frame_n == 20) ? 16'($urandom_range(256, 300)) : 16'($urandom_range(0, 12));
      split_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len + 4) : -1;
      send_frame(len, kind, FILL_RANDOM, split_at, 8'($urandom_range(0, 255)));
      frame_n++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
